// File: hdl/wsd_pkg.sv
// Shared types and codes for the work-stealing deque core.
// Request and response payload structs, operation and status codes.
// No dependencies.
package wsd_pkg;

	localparam int LOG_CAPACITY_DEF = 10;
	localparam int HANDLE_WIDTH_DEF = 64;

	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;
	localparam int TASK_W = 64;
	localparam int OCC_W = 11;

	localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STEAL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TASK_W-1:0] task_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TASK_W-1:0]   task_out;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

endpackage

// File: hdl/wsd_store.sv
// Task handle store: one write port, one read port, registered read data.
// Depends on nothing; widths come from the top level.
module wsd_store #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/work_stealing_deque_core.sv
// Work-stealing deque core: owner push/pop at the bottom, thief steal at the top.
// Uses wsd_pkg for payload types and codes, wsd_store for the task handles.
//
//   channel   signals                       payload
//   request   in_valid / in_ready           in_req  (req_t: kind, task_in)
//   response  out_valid / out_ready         out_rsp (rsp_t: status, task_out, occupancy)
//
// One request per cycle is sustained while out_ready stays high. Indices update at the
// accept edge, where the store read data is registered too (read stage); the output
// register follows. A store write is visible to any later read; no forwarding is needed.
// Reset clears the indices and the pipeline valids; the store itself is not cleared.
// A stalled response holds the read stage, which in turn holds in_ready low.
module work_stealing_deque_core
	import wsd_pkg::*;
#(
	parameter int LOG_CAPACITY = LOG_CAPACITY_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_rsp
);

	localparam int IW = LOG_CAPACITY + 1;
	localparam logic [IW-1:0] CAP_IDX = {1'b1, {LOG_CAPACITY{1'b0}}};
	localparam logic [IW-1:0] ONE_IDX = {{LOG_CAPACITY{1'b0}}, 1'b1};

	logic [IW-1:0] top_q, bot_q, top_nxt, bot_nxt;
	logic [IW-1:0] held, occ_nxt, bot_dec;
	logic          accept, advance;
	logic          wr_en, rd_en, take;
	logic [LOG_CAPACITY-1:0] rd_addr;
	logic [STATUS_W-1:0]     status;
	logic [HANDLE_WIDTH-1:0] rd_data;

	logic                valid_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [IW-1:0]       occ_s1;
	logic                take_s1;

	logic out_valid_q;
	rsp_t out_q;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept = in_valid && in_ready;

	assign held = bot_q - top_q;
	assign bot_dec = bot_q - ONE_IDX;

	always_comb begin
		top_nxt = top_q;
		bot_nxt = bot_q;
		wr_en = 1'b0;
		rd_en = 1'b0;
		take = 1'b0;
		rd_addr = top_q[LOG_CAPACITY-1:0];
		status = ST_EMPTY;
		case (in_req.kind)
			KIND_PUSH: begin
				if (held == CAP_IDX) begin
					status = ST_FULL;
				end else begin
					wr_en = accept;
					bot_nxt = bot_q + ONE_IDX;
					status = ST_OK;
				end
			end
			KIND_POP: begin
				rd_addr = bot_dec[LOG_CAPACITY-1:0];
				if (held != '0) begin
					rd_en = accept;
					take = 1'b1;
					status = ST_OK;
					if (held == ONE_IDX) begin
						top_nxt = top_q + ONE_IDX;
					end else begin
						bot_nxt = bot_dec;
					end
				end
			end
			KIND_STEAL: begin
				if (held != '0) begin
					rd_en = accept;
					take = 1'b1;
					status = ST_OK;
					top_nxt = top_q + ONE_IDX;
				end
			end
			default: begin
				status = ST_EMPTY;
			end
		endcase
		occ_nxt = bot_nxt - top_nxt;
	end

	wsd_store #(
		.ADDR_W(LOG_CAPACITY),
		.DATA_W(HANDLE_WIDTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(bot_q[LOG_CAPACITY-1:0]),
		.wr_data(in_req.task_in[HANDLE_WIDTH-1:0]),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			bot_q <= '0;
		end else if (accept) begin
			top_q <= top_nxt;
			bot_q <= bot_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			occ_s1 <= occ_nxt;
			take_s1 <= take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.status <= status_s1;
			out_q.task_out <= take_s1 ? TASK_W'(rd_data) : '0;
			out_q.occupancy <= OCC_W'(occ_s1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp = out_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bot_q - top_q) <= CAP_IDX)
		else $error("occupancy beyond capacity");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(status_s1) && $stable(occ_s1))
		else $error("read stage changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.task_out == '0)
		else $error("failed request returned a task");

	a_idx_still: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(top_q) && $stable(bot_q))
		else $error("indices moved without a request");

endmodule

// File: sim/wsd_checker.sv
`timescale 1ns / 1ps
// Request/response checker for work_stealing_deque_core: predicts each response from
// its own copy of the task store and indices, and compares responses in order.
// Depends on wsd_pkg for payload types and operation/status codes.
module wsd_checker
	import wsd_pkg::*;
#(
	parameter int LOG_CAPACITY = LOG_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  req_t in_req,
	input  logic out_valid,
	input  logic out_ready,
	input  rsp_t out_rsp,
	output int   errors,
	output int   pending,
	output int   checked,
	output int   held_now,
	output int   peak_held
);

	localparam int CAP = 1 << LOG_CAPACITY;
	localparam int IW = LOG_CAPACITY + 1;

	logic [TASK_W-1:0] slots [CAP];
	logic [IW-1:0] top_idx;
	logic [IW-1:0] bot_idx;
	rsp_t owed_rsp [$];

	function automatic rsp_t deque_op(req_t r);
		rsp_t e;
		logic [IW-1:0] n;
		logic [IW-1:0] b;
		e = '0;
		e.status = ST_EMPTY;
		n = bot_idx - top_idx;
		case (r.kind)
			KIND_PUSH: begin
				if (n >= CAP) begin
					e.status = ST_FULL;
				end else begin
					slots[bot_idx[LOG_CAPACITY-1:0]] = r.task_in;
					bot_idx = bot_idx + 1'b1;
					e.status = ST_OK;
				end
			end
			KIND_POP: begin
				if (n != 0) begin
					b = bot_idx - 1'b1;
					e.task_out = slots[b[LOG_CAPACITY-1:0]];
					if (n == 1)
						top_idx = top_idx + 1'b1;
					else
						bot_idx = b;
					e.status = ST_OK;
				end
			end
			KIND_STEAL: begin
				if (n != 0) begin
					e.task_out = slots[top_idx[LOG_CAPACITY-1:0]];
					top_idx = top_idx + 1'b1;
					e.status = ST_OK;
				end
			end
			default: ;
		endcase
		n = bot_idx - top_idx;
		e.occupancy = OCC_W'(n);
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			top_idx = '0;
			bot_idx = '0;
			owed_rsp.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			held_now = 0;
			peak_held = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_rsp.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: status %0d task %h occupancy %0d",
							out_rsp.status, out_rsp.task_out, out_rsp.occupancy);
				end else begin
					exp_rsp = owed_rsp.pop_front();
					checked++;
					if (out_rsp.status !== exp_rsp.status ||
						out_rsp.task_out !== exp_rsp.task_out ||
						out_rsp.occupancy !== exp_rsp.occupancy) begin
						errors++;
						if (errors <= 10)
							$display({"response %0d mismatch (expected/actual): status %0d/%0d ",
								"task %h/%h occupancy %0d/%0d"}, checked,
								exp_rsp.status, out_rsp.status,
								exp_rsp.task_out, out_rsp.task_out,
								exp_rsp.occupancy, out_rsp.occupancy);
					end
				end
			end
			if (in_valid && in_ready) begin
				owed_rsp.push_back(deque_op(in_req));
				held_now = int'(IW'(bot_idx - top_idx));
				if (held_now > peak_held)
					peak_held = held_now;
			end
			pending = owed_rsp.size();
		end
	end

endmodule

// File: sim/work_stealing_deque_core_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for work_stealing_deque_core: drives push/pop/steal requests with
// random gaps and back-pressure, gives the verdict. Depends on wsd_pkg and wsd_checker.
module work_stealing_deque_core_tb
	import wsd_pkg::*;
;

	localparam int CAPACITY = 1 << LOG_CAPACITY_DEF;
	localparam int IDLE_PCT = 37;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_rsp;

	int errors;
	int pending;
	int checked;
	int held_now;
	int peak_held;
	int sent [4];
	int stall_cycles = 0;
	bit quiet = 1'b0;

	work_stealing_deque_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rsp(out_rsp)
	);

	wsd_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rsp(out_rsp),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.held_now(held_now),
		.peak_held(peak_held)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(negedge clk);
			out_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("work_stealing_deque_core_tb NOT OK");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

	function automatic logic [TASK_W-1:0] rand_handle();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(int push_pct, int pop_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return KIND_PUSH;
		else if (r < push_pct + pop_pct)
			return KIND_POP;
		else if (r < 99)
			return KIND_STEAL;
		else
			return KIND_RSVD;
	endfunction

	task automatic send(input logic [KIND_W-1:0] k, input logic [TASK_W-1:0] h);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_req.kind = k;
		in_req.task_in = h;
		do @(posedge clk); while (!in_ready);
		sent[k]++;
	endtask

	task automatic run_mix(int count, int push_pct, int pop_pct);
		repeat (count) send(pick_kind(push_pct, pop_pct), rand_handle());
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty deque, reserved code, zero and all-ones handles, last-task pop
		send(KIND_POP, rand_handle());
		send(KIND_STEAL, rand_handle());
		send(KIND_RSVD, rand_handle());
		send(KIND_PUSH, '0);
		send(KIND_POP, rand_handle());
		send(KIND_PUSH, '1);
		send(KIND_STEAL, '0);
		send(KIND_PUSH, 64'h8000_0000_0000_0000);
		send(KIND_PUSH, 64'h0000_0000_0000_0001);
		send(KIND_PUSH, 64'h5555_5555_5555_5555);
		send(KIND_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
		send(KIND_RSVD, '1);
		send(KIND_POP, '1);
		send(KIND_STEAL, rand_handle());
		send(KIND_POP, rand_handle());
		send(KIND_POP, rand_handle());
		send(KIND_POP, rand_handle());
		send(KIND_STEAL, rand_handle());

		run_mix(250, 45, 27);
		drain();

		quiet = 1'b1;
		run_mix(300, 95, 2);
		quiet = 1'b0;

		// fill to capacity, then push against the full store
		guard = 0;
		while (held_now < CAPACITY && guard < 1500) begin
			send(pick_kind(95, 2), rand_handle());
			guard++;
		end
		run_mix(40, 70, 15);
		run_mix(150, 10, 45);

		drain();
		repeat (6) @(posedge clk);

		$display("requests: %0d push, %0d pop, %0d steal, %0d reserved code",
			sent[KIND_PUSH], sent[KIND_POP], sent[KIND_STEAL], sent[KIND_RSVD]);
		$display("responses compared: %0d, occupancy peaked at %0d of %0d",
			checked, peak_held, CAPACITY);
		if (errors == 0)
			$display("work_stealing_deque_core_tb OK");
		else
			$display("work_stealing_deque_core_tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
hdl/wsd_pkg.sv
hdl/wsd_store.sv
hdl/work_stealing_deque_core.sv
sim/wsd_checker.sv
sim/work_stealing_deque_core_tb.sv
